### rtl/dtps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtps_pkg;

  // Shared bit-serial divider geometry.
  localparam int DIV_W     = 33;
  localparam int DIVISOR_W = 17;
  localparam int STEP_W    = 6;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
    logic [STEP_W-1:0]    steps;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_W-1:0]     quo;
    logic [DIVISOR_W-1:0] rem;
  } div_rsp_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_SAMPLE_RATE    = 3'd0;
  localparam logic [2:0] REG_SAMPLE_FORMAT  = 3'd1;
  localparam logic [2:0] REG_CHANNEL_COUNT  = 3'd2;
  localparam logic [2:0] REG_REPEAT_FOREVER = 3'd3;
  localparam logic [2:0] REG_TONE_COUNT     = 3'd4;
  localparam logic [2:0] REG_TONE_FIRST     = 3'd5;
  localparam logic [2:0] REG_TONE_SECOND    = 3'd6;
  localparam logic [2:0] REG_TONE_THIRD     = 3'd7;

  // Sample format codes.
  localparam logic [2:0] FMT_U8      = 3'd0;
  localparam logic [2:0] FMT_S8      = 3'd1;
  localparam logic [2:0] FMT_U16_LE  = 3'd2;
  localparam logic [2:0] FMT_U16_BE  = 3'd3;
  localparam logic [2:0] FMT_S16_LE  = 3'd4;
  localparam logic [2:0] FMT_S16_BE  = 3'd5;

  localparam logic [22:0] FRAMES_MAX   = 23'h7FFFFF;
  localparam logic [16:0] MS_PER_SEC   = 17'd1000;
  localparam logic [16:0] U_SPAN       = 17'd65534;
  localparam logic [16:0] S_FULL       = 17'd32767;
  localparam logic [15:0] MIN_TONE_HZ  = 16'd10;
  localparam logic [STEP_W-1:0] STEPS_PHASE  = 6'd17;
  localparam logic [STEP_W-1:0] STEPS_FREQ   = 6'd16;
  localparam logic [STEP_W-1:0] STEPS_FRAMES = 6'd33;
  localparam logic [STEP_W-1:0] STEPS_U8     = 6'd24;
  localparam logic [STEP_W-1:0] STEPS_S8     = 6'd22;
  localparam logic [STEP_W-1:0] STEPS_U16    = 6'd32;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

  // One Q1.15 sine table entry from its position in a turn (Q32).
  // Evaluated only on constants while the table is elaborated.
  function automatic logic signed [15:0] sine_entry(input logic [63:0] turn);
    logic [63:0] w, x, x2, term, pos, neg, s, v, p;
    logic [1:0]  quad;
    quad = turn[31:30];
    w = turn & (Q30_ONE - 64'd1);
    if (quad[0]) begin
      w = Q30_ONE - w;
    end
    x = (w * Q30_HALF_PI) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    pos = x;
    neg = 64'd0;
    for (int n = 1; n <= 8; n++) begin
      p = (term * x2) >> 30;
      case (n)
        1: term = p / 64'd6;
        2: term = p / 64'd20;
        3: term = p / 64'd42;
        4: term = p / 64'd72;
        5: term = p / 64'd110;
        6: term = p / 64'd156;
        7: term = p / 64'd210;
        default: term = p / 64'd272;
      endcase
      if (n % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    if (neg >= pos) begin
      s = 64'd0;
    end else begin
      s = pos - neg;
      if (s > Q30_ONE) begin
        s = Q30_ONE;
      end
    end
    v = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return quad[1] ? 16'(-v) : 16'(v);
  endfunction

endpackage

`default_nettype wire

### rtl/dtps_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module dtps_div
  import dtps_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 busy;
  logic                 done;
  logic [STEP_W-1:0]    cnt;
  logic [DIV_W-1:0]     dsr;
  logic [DIV_W-1:0]     quo;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] divisor;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;
  logic [DIVISOR_W-1:0] rem_next;

  always_comb begin
    trial = {rem, dsr[DIV_W-1]};
    fits = trial >= {1'b0, divisor};
    rem_next = fits ? DIVISOR_W'(trial - {1'b0, divisor}) : trial[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= req.steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dsr <= req.dividend << (STEP_W'(DIV_W) - req.steps);
      rem <= '0;
      quo <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      dsr <= {dsr[DIV_W-2:0], 1'b0};
      rem <= rem_next;
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quo = quo;
  assign rsp.rem = rem;

endmodule

`default_nettype wire

### rtl/dtps_sine_rom.sv
`timescale 1ns / 1ps
`default_nettype none

// Constant Q1.15 sine table with a registered read.
module dtps_sine_rom
  import dtps_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic                                clk,
  input  wire logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr,
  output logic signed [15:0]                       q
);

  logic signed [15:0] rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_entry
    localparam logic [63:0] TURN = (64'(k) << 32) / SINE_TABLE_DEPTH;
    localparam logic signed [15:0] VAL = sine_entry(TURN);
    assign rom[k] = VAL;
  end

  always_ff @(posedge clk) begin
    q <= rom[addr];
  end

endmodule

`default_nettype wire

### rtl/dual_tone_pcm_sequencer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Dual-tone PCM sequencer. Every input word asks for one PCM frame: the block
// plays a sequence of up to three tones, each silence, one sine or the average
// of two sines, and returns channel_count output words per frame, all carrying
// the same formatted sample (u8, s8, u16 or s16, little or big endian). A tone
// lasts sample_rate * ms / 1000 frames and restarts its phases when it starts.
// With repeat_forever clear the sequence plays once; the frame that completes
// it is flagged by end_of_signal, and later input words give no output until
// one arrives with restart set. All arithmetic goes through one shared
// restoring divider that yields one quotient bit per clock, and the
// sequencer waits for each operation to finish. Each phase accumulator costs
// a 17-bit phase reduction and a 16-bit frequency reduction; each sounding
// sine adds a table index of 17 + $clog2(SINE_TABLE_DEPTH + 1) bits and a
// registered table read; each tone duration that must be worked out costs a
// 33-bit division; and the u8, s8 and u16 formats add a 24, 22 or 32 bit
// scaling. Each output word is held until the receiver takes it. A word that
// arrives after a single play has ended is taken while the block stays idle.
// One input word is taken at a time, and in_ready is high only between
// frames. The user must write configuration only while idle; the block
// itself does not enforce it.
module dual_tone_pcm_sequencer_top
  import dtps_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int MAX_TONES        = 3,
  parameter int MAX_CHANNELS     = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        restart,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      sample_bits,
  output logic [2:0]       channel_index,
  output logic             last_in_frame,
  output logic             end_of_signal
);

  localparam int IW = $clog2(SINE_TABLE_DEPTH);
  localparam logic [STEP_W-1:0] STEPS_INDEX = STEP_W'(17 + $clog2(SINE_TABLE_DEPTH + 1));

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FIND    = 4'd1;
  localparam logic [3:0] S_FOUND   = 4'd2;
  localparam logic [3:0] S_WAIT    = 4'd3;
  localparam logic [3:0] S_PM_GOT  = 4'd4;
  localparam logic [3:0] S_IDX_GOT = 4'd5;
  localparam logic [3:0] S_ROM     = 4'd6;
  localparam logic [3:0] S_ADV     = 4'd7;
  localparam logic [3:0] S_TAIL    = 4'd8;
  localparam logic [3:0] S_NXT     = 4'd9;
  localparam logic [3:0] S_NXT_GOT = 4'd10;
  localparam logic [3:0] S_FMT     = 4'd11;
  localparam logic [3:0] S_FMT_GOT = 4'd12;
  localparam logic [3:0] S_EMIT    = 4'd13;

  // Configuration registers.
  logic [16:0] sample_rate;
  logic [2:0]  sample_format;
  logic [3:0]  channel_count;
  logic        repeat_forever;
  logic [1:0]  tone_count;
  logic [47:0] tone_reg [3];

  // Sequencer state.
  logic [3:0]         state;
  logic [3:0]         ret;
  logic [1:0]         tone_slot;
  logic [22:0]        frames_left;
  logic [16:0]        phase_primary;
  logic [16:0]        phase_secondary;
  logic               finished;
  logic [1:0]         cand;
  logic [1:0]         cnt;
  logic               second;
  logic [16:0]        pm;
  logic signed [15:0] v;
  logic               ends;
  logic [15:0]        sample;
  logic [2:0]         ch;

  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic signed [15:0] rom_q;

  // Derived values.
  logic [16:0] rate_eff;
  logic [1:0]  ntones;
  logic [3:0]  chans;
  logic [1:0]  tsel;
  logic [47:0] tone_cur;
  logic [15:0] f1;
  logic [15:0] f2;
  logic [15:0] fsel;
  logic [22:0] fsat;
  logic        rom_need;
  logic [17:0] ph_sum;
  logic [16:0] ph_new;
  logic signed [16:0] pair_sum;
  logic signed [16:0] pair_half;
  logic [16:0] u_off;
  logic [14:0] mag;
  logic        fin0;
  logic [1:0]  slot0;
  logic [1:0]  slot_fix;
  logic [22:0] frames0;

  always_comb begin
    rate_eff = (sample_rate == 17'd0) ? 17'd1 : sample_rate;
    ntones = (tone_count == 2'd0) ? 2'd1 : tone_count;
    if (ntones > 2'(MAX_TONES)) begin
      ntones = 2'(MAX_TONES);
    end
    chans = (channel_count == 4'd0) ? 4'd1 : channel_count;
    if (chans > 4'(MAX_CHANNELS)) begin
      chans = 4'(MAX_CHANNELS);
    end
    tsel = (state == S_FIND || state == S_NXT) ? cand : tone_slot;
    case (tsel)
      2'd0: tone_cur = tone_reg[0];
      2'd1: tone_cur = tone_reg[1];
      2'd2: tone_cur = tone_reg[2];
      default: tone_cur = '0;
    endcase
    f1 = tone_cur[15:0];
    f2 = tone_cur[31:16];
    fsel = second ? f2 : f1;
    fsat = (div_rsp.quo > DIV_W'(FRAMES_MAX)) ? FRAMES_MAX : div_rsp.quo[22:0];
    rom_need = (f1 > MIN_TONE_HZ) && (!second || f2 != 16'd0);
    ph_sum = {1'b0, pm} + {1'b0, div_rsp.rem};
    ph_new = (ph_sum >= {1'b0, rate_eff}) ? 17'(ph_sum - {1'b0, rate_eff}) : ph_sum[16:0];
    pair_sum = 17'(v) + 17'(rom_q);
    pair_half = pair_sum[16] ? ((pair_sum + 17'sd1) >>> 1) : (pair_sum >>> 1);
    u_off = {v[15], v} + 17'd32767;
    mag = v[15] ? 15'(-v) : v[14:0];
    fin0 = restart ? 1'b0 : finished;
    slot0 = restart ? 2'd0 : tone_slot;
    slot_fix = (slot0 >= ntones) ? 2'd0 : slot0;
    frames0 = restart ? 23'd0 : frames_left;
  end

  // Divider commands: each issuing state loads one operation.
  always_comb begin
    div_req = '0;
    unique case (state) inside
      S_IDLE: begin
        if (in_valid && !fin0 && frames0 != 23'd0) begin
          div_req.start = 1'b1;
          div_req.dividend = DIV_W'(phase_primary);
          div_req.divisor = rate_eff;
          div_req.steps = STEPS_PHASE;
        end
      end
      S_FIND, S_NXT: begin
        if (state == S_FIND || cand < ntones) begin
          div_req.start = 1'b1;
          div_req.dividend = DIV_W'(rate_eff) * DIV_W'(tone_cur[47:32]);
          div_req.divisor = MS_PER_SEC;
          div_req.steps = STEPS_FRAMES;
        end
      end
      S_FOUND, S_ADV: begin
        if ((state == S_FOUND && fsat != 23'd0) || (state == S_ADV && !second)) begin
          div_req.start = 1'b1;
          div_req.dividend = (state == S_FOUND) ? DIV_W'(0) : DIV_W'(phase_secondary);
          div_req.divisor = rate_eff;
          div_req.steps = STEPS_PHASE;
        end
      end
      S_PM_GOT: begin
        div_req.start = 1'b1;
        div_req.divisor = rate_eff;
        if (rom_need) begin
          div_req.dividend = DIV_W'(div_rsp.rem) * DIV_W'(SINE_TABLE_DEPTH);
          div_req.steps = STEPS_INDEX;
        end else begin
          div_req.dividend = DIV_W'(fsel);
          div_req.steps = STEPS_FREQ;
        end
      end
      S_ROM: begin
        div_req.start = 1'b1;
        div_req.dividend = DIV_W'(fsel);
        div_req.divisor = rate_eff;
        div_req.steps = STEPS_FREQ;
      end
      S_FMT: begin
        case (sample_format) inside
          FMT_U8: begin
            div_req.start = 1'b1;
            div_req.dividend = DIV_W'({u_off, 8'h00}) - DIV_W'(u_off);
            div_req.divisor = U_SPAN;
            div_req.steps = STEPS_U8;
          end
          FMT_S8: begin
            div_req.start = 1'b1;
            div_req.dividend = DIV_W'({mag, 7'h00}) - DIV_W'(mag);
            div_req.divisor = S_FULL;
            div_req.steps = STEPS_S8;
          end
          FMT_U16_LE, FMT_U16_BE: begin
            div_req.start = 1'b1;
            div_req.dividend = DIV_W'({u_off, 16'h0000}) - DIV_W'(u_off);
            div_req.divisor = U_SPAN;
            div_req.steps = STEPS_U16;
          end
          default: begin
            div_req.start = 1'b0;
          end
        endcase
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  dtps_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  dtps_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .addr (div_rsp.quo[IW-1:0]),
    .q    (rom_q)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= 17'd44100;
      sample_format <= FMT_S16_LE;
      channel_count <= 4'd1;
      repeat_forever <= 1'b0;
      tone_count <= 2'd1;
      tone_reg[0] <= '0;
      tone_reg[1] <= '0;
      tone_reg[2] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SAMPLE_RATE:    sample_rate <= cfg_data[16:0];
        REG_SAMPLE_FORMAT:  sample_format <= cfg_data[2:0];
        REG_CHANNEL_COUNT:  channel_count <= cfg_data[3:0];
        REG_REPEAT_FOREVER: repeat_forever <= cfg_data[0];
        REG_TONE_COUNT:     tone_count <= cfg_data[1:0];
        REG_TONE_FIRST:     tone_reg[0] <= cfg_data;
        REG_TONE_SECOND:    tone_reg[1] <= cfg_data;
        REG_TONE_THIRD:     tone_reg[2] <= cfg_data;
        default:            sample_rate <= sample_rate;
      endcase
    end
  end

  // Frame sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      tone_slot <= 2'd0;
      frames_left <= 23'd0;
      phase_primary <= 17'd0;
      phase_secondary <= 17'd0;
      finished <= 1'b0;
      cand <= 2'd0;
      cnt <= 2'd0;
      second <= 1'b0;
      ends <= 1'b0;
      ch <= 3'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (restart) begin
              finished <= 1'b0;
            end
            if (!fin0) begin
              // A frame starts silent until a sine is looked up.
              tone_slot <= slot_fix;
              v <= 16'sd0;
              ends <= 1'b0;
              second <= 1'b0;
              if (frames0 == 23'd0) begin
                frames_left <= 23'd0;
                cand <= slot_fix;
                cnt <= 2'd0;
                phase_primary <= 17'd0;
                phase_secondary <= 17'd0;
                state <= S_FIND;
              end else begin
                ret <= S_PM_GOT;
                state <= S_WAIT;
              end
            end
          end
        end
        S_FIND: begin
          ret <= S_FOUND;
          state <= S_WAIT;
        end
        S_FOUND: begin
          if (fsat != 23'd0) begin
            tone_slot <= cand;
            frames_left <= fsat;
            ret <= S_PM_GOT;
            state <= S_WAIT;
          end else if (cnt == ntones - 2'd1) begin
            // Every tone is empty: a silent frame.
            ends <= !repeat_forever;
            state <= S_FMT;
          end else begin
            cnt <= cnt + 2'd1;
            cand <= (cand + 2'd1 == ntones) ? 2'd0 : cand + 2'd1;
            state <= S_FIND;
          end
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            state <= ret;
          end
        end
        S_PM_GOT: begin
          pm <= div_rsp.rem;
          ret <= rom_need ? S_IDX_GOT : S_ADV;
          state <= S_WAIT;
        end
        S_IDX_GOT: begin
          state <= S_ROM;
        end
        S_ROM: begin
          v <= second ? pair_half[15:0] : rom_q;
          ret <= S_ADV;
          state <= S_WAIT;
        end
        S_ADV: begin
          if (!second) begin
            phase_primary <= ph_new;
            second <= 1'b1;
            ret <= S_PM_GOT;
            state <= S_WAIT;
          end else begin
            phase_secondary <= ph_new;
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          frames_left <= frames_left - 23'd1;
          if (frames_left == 23'd1) begin
            cand <= tone_slot + 2'd1;
            state <= S_NXT;
          end else begin
            state <= S_FMT;
          end
        end
        S_NXT: begin
          if (cand >= ntones) begin
            tone_slot <= 2'd0;
            ends <= !repeat_forever;
            state <= S_FMT;
          end else begin
            ret <= S_NXT_GOT;
            state <= S_WAIT;
          end
        end
        S_NXT_GOT: begin
          if (fsat == 23'd0) begin
            cand <= cand + 2'd1;
            state <= S_NXT;
          end else begin
            tone_slot <= cand;
            state <= S_FMT;
          end
        end
        S_FMT: begin
          if (ends) begin
            finished <= 1'b1;
          end
          ch <= 3'd0;
          if (div_req.start) begin
            ret <= S_FMT_GOT;
            state <= S_WAIT;
          end else begin
            sample <= (sample_format == FMT_S16_BE) ? {v[7:0], v[15:8]} : v;
            state <= S_EMIT;
          end
        end
        S_FMT_GOT: begin
          case (sample_format)
            FMT_U8: sample <= {8'h00, div_rsp.quo[7:0]};
            FMT_S8: sample <= {8'h00, v[15] ? 8'(~div_rsp.quo[7:0] + 8'd1)
                                            : div_rsp.quo[7:0]};
            FMT_U16_BE: sample <= {div_rsp.quo[7:0], div_rsp.quo[15:8]};
            default: sample <= div_rsp.quo[15:0];
          endcase
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_ready) begin
            if ({1'b0, ch} == chans - 4'd1) begin
              state <= S_IDLE;
            end else begin
              ch <= ch + 3'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign sample_bits = sample;
  assign channel_index = ch;
  assign last_in_frame = ({1'b0, ch} == chans - 4'd1);
  assign end_of_signal = ends;

  // A divider result only arrives while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_WAIT)
    else $error("divider finished outside the wait state");

  // An accepted word never produces output in the very next cycle.
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid)
    else $error("output word before the frame was computed");

  // The last word of a frame returns the block to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_in_frame |=> in_ready)
    else $error("block did not return to idle after a frame");

  // The current tone always names one of the three tone registers.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    tone_slot != 2'd3)
    else $error("tone slot out of range");

endmodule

`default_nettype wire
